// File: rtl/core/assert_macros.svh
// Assertion macros for the decoder RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication checked every clock, masked during reset.
`define ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("decoder assertion failed");

// Next-cycle implication checked every clock, masked during reset.
`define ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("decoder assertion failed");

`endif

// File: rtl/core/m68k_pkg.sv
// Shared types and class codes for the 68000 opcode class decoder.
// No dependencies; used by m68k_dec_core and the top level.
`default_nettype none

package m68k_pkg;

  localparam int unsigned OPC_W = 16;
  localparam int unsigned CLS_W = 6;
  localparam int unsigned CC_W  = 4;

  // Internal decode result: class codes plus two markers above the class range.
  typedef logic [CLS_W:0] kind_t;

  localparam kind_t K_NONE     = 7'd0;
  localparam kind_t K_ABCD     = 7'd1;
  localparam kind_t K_ADD      = 7'd2;
  localparam kind_t K_ADDA     = 7'd3;
  localparam kind_t K_ADDI     = 7'd4;
  localparam kind_t K_ADDQ     = 7'd5;
  localparam kind_t K_ADDX     = 7'd6;
  localparam kind_t K_AND      = 7'd7;
  localparam kind_t K_ANDI     = 7'd8;
  localparam kind_t K_ANDI_CCR = 7'd9;
  localparam kind_t K_ANDI_SR  = 7'd10;
  localparam kind_t K_ASL      = 7'd11;
  localparam kind_t K_ASR      = 7'd12;
  localparam kind_t K_BCC      = 7'd13;
  localparam kind_t K_BCHG     = 7'd14;
  localparam kind_t K_BCLR     = 7'd15;
  localparam kind_t K_BSET     = 7'd16;
  localparam kind_t K_BTST     = 7'd17;
  localparam kind_t K_CLR      = 7'd18;
  localparam kind_t K_CMP      = 7'd19;
  localparam kind_t K_CMPA     = 7'd20;
  localparam kind_t K_CMPI     = 7'd21;
  localparam kind_t K_CMPM     = 7'd22;
  localparam kind_t K_DBCC     = 7'd23;
  localparam kind_t K_DIVS     = 7'd24;
  localparam kind_t K_DIVU     = 7'd25;
  localparam kind_t K_EOR      = 7'd26;
  localparam kind_t K_EORI     = 7'd27;
  localparam kind_t K_EXG      = 7'd28;
  localparam kind_t K_EXT      = 7'd29;
  localparam kind_t K_JMP      = 7'd30;
  localparam kind_t K_LEA      = 7'd31;
  localparam kind_t K_LSL      = 7'd32;
  localparam kind_t K_LSR      = 7'd33;
  localparam kind_t K_MOVE     = 7'd34;
  localparam kind_t K_MOVE_CCR = 7'd35;
  localparam kind_t K_MOVE_SR  = 7'd36;
  localparam kind_t K_MOVE_USP = 7'd37;
  localparam kind_t K_MOVEA    = 7'd38;
  localparam kind_t K_MOVEM    = 7'd39;
  localparam kind_t K_MOVEP    = 7'd40;
  localparam kind_t K_MOVEQ    = 7'd41;
  localparam kind_t K_MULS     = 7'd42;
  localparam kind_t K_MULU     = 7'd43;
  localparam kind_t K_NBCD     = 7'd44;
  localparam kind_t K_NEG      = 7'd45;
  localparam kind_t K_NOT      = 7'd46;
  localparam kind_t K_OR       = 7'd47;
  localparam kind_t K_ORI      = 7'd48;
  localparam kind_t K_ROL      = 7'd49;
  localparam kind_t K_ROR      = 7'd50;
  localparam kind_t K_ROXL     = 7'd51;
  localparam kind_t K_ROXR     = 7'd52;
  localparam kind_t K_SBCD     = 7'd53;
  localparam kind_t K_SCC      = 7'd54;
  localparam kind_t K_SUB      = 7'd55;
  localparam kind_t K_SUBA     = 7'd56;
  localparam kind_t K_SUBI     = 7'd57;
  localparam kind_t K_SUBQ     = 7'd58;
  localparam kind_t K_SUBX     = 7'd59;
  localparam kind_t K_SWAP     = 7'd60;
  localparam kind_t K_TAS      = 7'd61;
  localparam kind_t K_TST      = 7'd62;
  localparam kind_t K_UNLK     = 7'd63;
  localparam kind_t K_UNIMP    = 7'd64;
  localparam kind_t K_STOP     = 7'd65;

  // Immediate low byte selecting the CCR / SR forms in line 0.
  localparam logic [7:0] LO_CCR = 8'h3C;
  localparam logic [7:0] LO_SR  = 8'h7C;

  typedef struct packed {
    logic             unimp;
    logic             halt;
    logic [CC_W-1:0]  cond;
    logic [CLS_W-1:0] cls;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/m68k_dec_core.sv
// Combinational decode tree: opcode word and odd-address flag to result fields.
// Depends on m68k_pkg.
`default_nettype none

module m68k_dec_core (
  input  wire logic [m68k_pkg::OPC_W-1:0] word,
  input  wire logic                       odd,
  output m68k_pkg::res_t                  res
);

  function automatic m68k_pkg::kind_t dec_line0(input logic [3:0] nib, input logic [7:0] lo);
    m68k_pkg::kind_t k;
    k = m68k_pkg::K_UNIMP;
    if (nib[0]) begin
      case (lo[7:6])
        2'd0:    k = m68k_pkg::K_BTST;
        2'd1:    k = m68k_pkg::K_BCHG;
        2'd2:    k = (lo[5:3] == 3'b001) ? m68k_pkg::K_MOVEP : m68k_pkg::K_BCLR;
        default: k = m68k_pkg::K_BSET;
      endcase
    end else begin
      case (nib)
        4'd0: begin
          k = (lo == m68k_pkg::LO_CCR || lo == m68k_pkg::LO_SR) ? m68k_pkg::K_UNIMP
                                                                : m68k_pkg::K_ORI;
        end
        4'd2: begin
          if (lo == m68k_pkg::LO_CCR)     k = m68k_pkg::K_ANDI_CCR;
          else if (lo == m68k_pkg::LO_SR) k = m68k_pkg::K_ANDI_SR;
          else                            k = m68k_pkg::K_ANDI;
        end
        4'd4:  k = m68k_pkg::K_SUBI;
        4'd6:  k = m68k_pkg::K_ADDI;
        4'd10: begin
          k = (lo == m68k_pkg::LO_CCR || lo == m68k_pkg::LO_SR) ? m68k_pkg::K_UNIMP
                                                                : m68k_pkg::K_EORI;
        end
        4'd12:   k = m68k_pkg::K_CMPI;
        default: k = m68k_pkg::K_UNIMP;
      endcase
    end
    return k;
  endfunction

  function automatic m68k_pkg::kind_t dec_line4(input logic [3:0] nib, input logic [7:0] lo);
    m68k_pkg::kind_t k;
    logic [1:0] sz;
    logic [2:0] mode;
    sz   = lo[7:6];
    mode = lo[5:3];
    k    = m68k_pkg::K_UNIMP;
    if (nib[0]) begin
      k = (sz == 2'd3) ? m68k_pkg::K_LEA : m68k_pkg::K_UNIMP;
    end else begin
      case (nib)
        4'd0: k = (sz == 2'd3) ? m68k_pkg::K_MOVE_SR : m68k_pkg::K_NEG;
        4'd2: k = m68k_pkg::K_CLR;
        4'd4: k = (sz == 2'd3) ? m68k_pkg::K_MOVE_CCR : m68k_pkg::K_NEG;
        4'd6: k = (sz == 2'd3) ? m68k_pkg::K_MOVE_SR : m68k_pkg::K_NOT;
        4'd8: begin
          case (sz)
            2'd0:    k = m68k_pkg::K_NBCD;
            2'd1:    k = (mode == 3'd0) ? m68k_pkg::K_SWAP : m68k_pkg::K_UNIMP;
            2'd2:    k = (mode == 3'd0) ? m68k_pkg::K_EXT : m68k_pkg::K_MOVEM;
            default: k = m68k_pkg::K_MOVEM;
          endcase
        end
        4'd10: k = (sz == 2'd3) ? m68k_pkg::K_TAS : m68k_pkg::K_TST;
        4'd12: k = sz[1] ? m68k_pkg::K_MOVEM : m68k_pkg::K_UNIMP;
        4'd14: begin
          if (sz == 2'd3)                      k = m68k_pkg::K_JMP;
          else if (sz != 2'd1)                 k = m68k_pkg::K_UNIMP;
          else if (mode == 3'd3)               k = m68k_pkg::K_UNLK;
          else if (mode == 3'd5)               k = m68k_pkg::K_MOVE_USP;
          else if (mode == 3'd6 && lo[2:0] == 3'd1) k = m68k_pkg::K_NONE;  // NOP
          else if (mode == 3'd6 && lo[2:0] == 3'd2) k = m68k_pkg::K_STOP;
          else                                 k = m68k_pkg::K_UNIMP;
        end
        default: k = m68k_pkg::K_UNIMP;
      endcase
    end
    return k;
  endfunction

  // Shared shape of lines 9 and 13: the address form (size field 3) wins over the X form.
  function automatic m68k_pkg::kind_t dec_arith(input logic [3:0] nib, input logic [7:0] lo,
                                                input m68k_pkg::kind_t plain,
                                                input m68k_pkg::kind_t addr,
                                                input m68k_pkg::kind_t ext);
    m68k_pkg::kind_t k;
    if (lo[7:6] == 2'd3)                  k = addr;
    else if (nib[0] && lo[5:4] == 2'd0)   k = ext;
    else                                  k = plain;
    return k;
  endfunction

  function automatic m68k_pkg::kind_t dec_shift(input logic [3:0] nib, input logic [7:0] lo);
    m68k_pkg::kind_t k;
    logic [1:0] kind;
    kind = (lo[7:6] == 2'd3) ? nib[2:1] : lo[4:3];
    case (kind)
      2'd0:    k = nib[0] ? m68k_pkg::K_ASL  : m68k_pkg::K_ASR;
      2'd1:    k = nib[0] ? m68k_pkg::K_LSL  : m68k_pkg::K_LSR;
      2'd2:    k = nib[0] ? m68k_pkg::K_ROXL : m68k_pkg::K_ROXR;
      default: k = nib[0] ? m68k_pkg::K_ROL  : m68k_pkg::K_ROR;
    endcase
    // memory shifts with bit 11 set have no handled class
    if (lo[7:6] == 2'd3 && nib[3]) k = m68k_pkg::K_UNIMP;
    return k;
  endfunction

  logic [3:0]      line;
  logic [3:0]      nib;
  logic [7:0]      lo;
  logic [1:0]      sz;
  m68k_pkg::kind_t kind;
  logic            halted;

  assign line   = word[15:12];
  assign nib    = word[11:8];
  assign lo     = word[7:0];
  assign sz     = lo[7:6];
  assign halted = odd || (word == '0);

  always_comb begin
    case (line)
      4'd0: kind = dec_line0(nib, lo);
      4'd1: kind = m68k_pkg::K_MOVE;
      4'd2, 4'd3: kind = (!nib[0] && sz == 2'd1) ? m68k_pkg::K_MOVEA : m68k_pkg::K_MOVE;
      4'd4: kind = dec_line4(nib, lo);
      4'd5: begin
        if (sz == 2'd3) kind = (lo[5:3] == 3'd1) ? m68k_pkg::K_DBCC : m68k_pkg::K_SCC;
        else            kind = nib[0] ? m68k_pkg::K_SUBQ : m68k_pkg::K_ADDQ;
      end
      4'd6: kind = (nib == 4'd1) ? m68k_pkg::K_UNIMP : m68k_pkg::K_BCC;  // BSR not handled
      4'd7: kind = nib[0] ? m68k_pkg::K_UNIMP : m68k_pkg::K_MOVEQ;
      4'd8: begin
        if (nib[0] && sz == 2'd0)
          kind = (lo[5:4] == 2'd0) ? m68k_pkg::K_SBCD : m68k_pkg::K_OR;
        else if (sz == 2'd3)
          kind = nib[0] ? m68k_pkg::K_DIVS : m68k_pkg::K_DIVU;
        else
          kind = m68k_pkg::K_OR;
      end
      4'd9: kind = dec_arith(nib, lo, m68k_pkg::K_SUB, m68k_pkg::K_SUBA, m68k_pkg::K_SUBX);
      4'd11: begin
        if (sz == 2'd3) kind = m68k_pkg::K_CMPA;
        else if (nib[0]) kind = (lo[5:3] == 3'b001) ? m68k_pkg::K_CMPM : m68k_pkg::K_EOR;
        else kind = m68k_pkg::K_CMP;
      end
      4'd12: begin
        if (nib[0] && lo[7:4] == 4'd0)
          kind = m68k_pkg::K_ABCD;
        else if (nib[0] && (lo[7:4] == 4'h4 || lo[7:3] == 5'b10001))
          kind = m68k_pkg::K_EXG;
        else if (sz == 2'd3)
          kind = nib[0] ? m68k_pkg::K_MULS : m68k_pkg::K_MULU;
        else
          kind = m68k_pkg::K_AND;
      end
      4'd13: kind = dec_arith(nib, lo, m68k_pkg::K_ADD, m68k_pkg::K_ADDA, m68k_pkg::K_ADDX);
      4'd14: kind = dec_shift(nib, lo);
      default: kind = m68k_pkg::K_UNIMP;  // line A and line F
    endcase
  end

  always_comb begin
    res = '0;
    if (halted) begin
      res.halt = 1'b1;
    end else if (kind == m68k_pkg::K_UNIMP) begin
      res.unimp = 1'b1;
    end else if (kind == m68k_pkg::K_STOP) begin
      res.halt = 1'b1;
    end else begin
      res.cls = kind[m68k_pkg::CLS_W-1:0];
      if (kind == m68k_pkg::K_BCC || kind == m68k_pkg::K_SCC || kind == m68k_pkg::K_DBCC)
        res.cond = nib;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/m68k_opcode_class_decoder.sv
// Top level of the 68000 opcode class decoder: input register, decode, result register.
// Depends on m68k_pkg, m68k_dec_core and assert_macros.svh.
//
// Usage:
//   s_* channel carries one opcode word per transaction (tdata) with the
//   odd-fetch-address flag in tuser. m_* channel returns one result per
//   input transaction: class number and condition field in tdata, halt and
//   unimplemented flags in tuser.
//   An accepted word is captured in the input register; the decode tree
//   feeds the result register, whose contents are presented on m_*.
//   Throughput: one transaction per cycle while m_tready stays high; the only
//   logic between the two registers is the single-pass decode tree.
//   Reset (rst, synchronous, active high) empties both stages; no results
//   are pending afterwards.
//   When m_tready is low the result register holds; the input register still
//   takes a word while it is empty, so s_tready falls only once both stages
//   are full. Results come out in input order, none dropped or repeated.
`default_nettype none

`include "assert_macros.svh"

module m68k_opcode_class_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] opcode_word
  input  wire logic [0:0]  s_tuser,   // [0] address_odd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [5:0] instr_class, [9:6] cond_code, [15:10] zero
  output logic [1:0]       m_tuser    // [0] halt_flag, [1] unimplemented
);

  logic                             in_valid;
  logic [m68k_pkg::OPC_W-1:0]       in_word;
  logic                             in_odd;
  logic                             out_valid;
  m68k_pkg::res_t                   out_res;
  m68k_pkg::res_t                   dec_res;
  logic                             advance;

  m68k_dec_core u_dec (
    .word (in_word),
    .odd  (in_odd),
    .res  (dec_res)
  );

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
    if (s_tready && s_tvalid) begin
      in_word <= s_tdata;
      in_odd  <= s_tuser[0];
    end
    if (advance && in_valid) begin
      out_res <= dec_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.cond, out_res.cls};
  assign m_tuser  = {out_res.unimp, out_res.halt};

  // a delivered result never carries both flags, and flagged results have no class
  `ASSERT_IMPL(a_flags_exclusive, m_tvalid, !(out_res.halt && out_res.unimp))
  `ASSERT_IMPL(a_flag_no_class, m_tvalid && (out_res.halt || out_res.unimp), out_res.cls == '0)
  // condition field only for the conditional classes
  `ASSERT_IMPL(a_cond_only_cc, m_tvalid && out_res.cond != '0,
               out_res.cls == m68k_pkg::K_BCC[m68k_pkg::CLS_W-1:0] ||
               out_res.cls == m68k_pkg::K_SCC[m68k_pkg::CLS_W-1:0] ||
               out_res.cls == m68k_pkg::K_DBCC[m68k_pkg::CLS_W-1:0])
  // back-pressure reaches the input only when both stages hold an item
  `ASSERT_IMPL(a_ready_full, !s_tready, in_valid && out_valid && !m_tready)
  // a held word in the input stage moves to the output once it drains
  `ASSERT_NEXT(a_stage_moves, in_valid && advance, out_valid)

endmodule

`default_nettype wire

// File: tb/m68k_opcode_class_decoder_tb.sv
// Self-checking testbench for m68k_opcode_class_decoder: directed and random opcode words.
// Depends on m68k_pkg and the decoder RTL; builds its own class prediction per word.
module m68k_opcode_class_decoder_tb;
  import m68k_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MIX_ITEMS = 600;
  localparam int unsigned FULL_RATE_ITEMS = 150;
  localparam int unsigned NUM_TEMPLATES = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // [15:0] opcode_word
  logic [0:0]  s_tuser = '0;  // [0] address_odd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // [5:0] instr_class, [9:6] cond_code, [15:10] zero
  logic [1:0]  m_tuser;       // [0] halt_flag, [1] unimplemented

  // calm: no idling on either side
  logic        calm = 1'b0;
  res_t        pending_decodes[$];
  res_t        want;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned halts_seen = 0;
  int unsigned unimp_seen = 0;
  logic [63:0] classes_seen = '0;

  m68k_opcode_class_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Decode tree over the opcode line and sub-fields; markers above the class range.
  function automatic kind_t decode_kind(input logic [15:0] w);
    logic [3:0] nib;
    logic [7:0] lo;
    logic [1:0] sz;
    logic [2:0] mode;
    logic [1:0] rot;
    kind_t      k;
    nib = w[11:8];
    lo = w[7:0];
    sz = lo[7:6];
    mode = lo[5:3];
    k = K_UNIMP;
    case (w[15:12])
      4'h0: begin
        if (nib[0]) begin
          case (sz)
            2'd0: k = K_BTST;
            2'd1: k = K_BCHG;
            2'd2: k = (mode == 3'd1) ? K_MOVEP : K_BCLR;
            default: k = K_BSET;
          endcase
        end else begin
          case (nib)
            4'h0: k = (lo == LO_CCR || lo == LO_SR) ? K_UNIMP : K_ORI;
            4'h2: k = (lo == LO_CCR) ? K_ANDI_CCR : (lo == LO_SR) ? K_ANDI_SR : K_ANDI;
            4'h4: k = K_SUBI;
            4'h6: k = K_ADDI;
            4'hA: k = (lo == LO_CCR || lo == LO_SR) ? K_UNIMP : K_EORI;
            4'hC: k = K_CMPI;
            default: k = K_UNIMP;
          endcase
        end
      end
      4'h1: k = K_MOVE;
      4'h2, 4'h3: k = (!nib[0] && sz == 2'd1) ? K_MOVEA : K_MOVE;
      4'h4: begin
        if (nib[0]) begin
          k = (sz == 2'd3) ? K_LEA : K_UNIMP;
        end else begin
          case (nib)
            4'h0: k = (sz == 2'd3) ? K_MOVE_SR : K_NEG;
            4'h2: k = K_CLR;
            4'h4: k = (sz == 2'd3) ? K_MOVE_CCR : K_NEG;
            4'h6: k = (sz == 2'd3) ? K_MOVE_SR : K_NOT;
            4'h8: begin
              case (sz)
                2'd0: k = K_NBCD;
                2'd1: k = (mode == 3'd0) ? K_SWAP : K_UNIMP;
                2'd2: k = (mode == 3'd0) ? K_EXT : K_MOVEM;
                default: k = K_MOVEM;
              endcase
            end
            4'hA: k = (sz == 2'd3) ? K_TAS : K_TST;
            4'hC: k = (sz > 2'd1) ? K_MOVEM : K_UNIMP;
            4'hE: begin
              if (sz == 2'd3) k = K_JMP;
              else if (sz != 2'd1) k = K_UNIMP;
              else if (mode == 3'd3) k = K_UNLK;
              else if (mode == 3'd5) k = K_MOVE_USP;
              else if (mode == 3'd6 && lo[2:0] == 3'd1) k = K_NONE;   // NOP
              else if (mode == 3'd6 && lo[2:0] == 3'd2) k = K_STOP;
              else k = K_UNIMP;
            end
            default: k = K_UNIMP;
          endcase
        end
      end
      4'h5: begin
        if (sz == 2'd3) k = (mode == 3'd1) ? K_DBCC : K_SCC;
        else k = nib[0] ? K_SUBQ : K_ADDQ;
      end
      4'h6: k = (nib == 4'h1) ? K_UNIMP : K_BCC;
      4'h7: k = nib[0] ? K_UNIMP : K_MOVEQ;
      4'h8: begin
        if (nib[0] && sz == 2'd0) k = (lo[5:4] == 2'd0) ? K_SBCD : K_OR;
        else if (nib[0]) k = (sz == 2'd3) ? K_DIVS : K_OR;
        else k = (sz == 2'd3) ? K_DIVU : K_OR;
      end
      4'h9: begin
        if (sz == 2'd3) k = K_SUBA;
        else if (nib[0] && lo[5:4] == 2'd0) k = K_SUBX;
        else k = K_SUB;
      end
      4'hB: begin
        if (sz == 2'd3) k = K_CMPA;
        else if (nib[0]) k = (mode == 3'd1) ? K_CMPM : K_EOR;
        else k = K_CMP;
      end
      4'hC: begin
        if (nib[0] && lo[7:4] == 4'h0) k = K_ABCD;
        // EXG: data/data, addr/addr (upper nibble 4) and data/addr (bits 7:3 = 0x11)
        else if (nib[0] && (lo[7:4] == 4'h4 || lo[7:3] == 5'h11)) k = K_EXG;
        else if (nib[0]) k = (sz == 2'd3) ? K_MULS : K_AND;
        else k = (sz == 2'd3) ? K_MULU : K_AND;
      end
      4'hD: begin
        if (sz == 2'd3) k = K_ADDA;
        else if (nib[0] && lo[5:4] == 2'd0) k = K_ADDX;
        else k = K_ADD;
      end
      4'hE: begin
        // memory shifts take the kind from bits 10:9, register shifts from bits 4:3
        if (sz == 2'd3 && nib[3]) begin
          k = K_UNIMP;
        end else begin
          rot = (sz == 2'd3) ? nib[2:1] : lo[4:3];
          case (rot)
            2'd0: k = nib[0] ? K_ASL : K_ASR;
            2'd1: k = nib[0] ? K_LSL : K_LSR;
            2'd2: k = nib[0] ? K_ROXL : K_ROXR;
            default: k = nib[0] ? K_ROL : K_ROR;
          endcase
        end
      end
      default: k = K_UNIMP;
    endcase
    return k;
  endfunction

  function automatic res_t classify_opcode(input logic [15:0] w, input logic odd);
    res_t  r;
    kind_t k;
    r = '0;
    if (w == 16'h0000 || odd) begin
      r.halt = 1'b1;
    end else begin
      k = decode_kind(w);
      if (k == K_UNIMP) begin
        r.unimp = 1'b1;
      end else if (k == K_STOP) begin
        r.halt = 1'b1;
      end else begin
        r.cls = k[CLS_W-1:0];
        if (k == K_BCC || k == K_SCC || k == K_DBCC) r.cond = w[11:8];
      end
    end
    return r;
  endfunction

  // {base, mask}: fixed bits plus the bits that are randomized
  function automatic logic [31:0] opcode_template(input int unsigned idx);
    case (idx)
      0:  return {16'h023C, 16'h0040};  // ANDI to CCR / SR
      1:  return {16'h003C, 16'h0A40};  // ORI / EORI to CCR / SR
      2:  return {16'h4E70, 16'h0007};  // NOP, STOP and neighbors
      3:  return {16'h4E40, 16'h003F};  // TRAP, LINK, UNLK, USP moves
      4:  return {16'h4840, 16'h003F};  // SWAP, PEA
      5:  return {16'h4880, 16'h047F};  // EXT, MOVEM
      6:  return {16'h0108, 16'h0EC7};  // MOVEP, dynamic bit ops
      7:  return {16'hC100, 16'h0E0F};  // ABCD
      8:  return {16'hC140, 16'h0E8F};  // EXG forms
      9:  return {16'h8100, 16'h0E0F};  // SBCD
      10: return {16'h9100, 16'h0ECF};  // SUBX / SUBA overlap
      11: return {16'hD100, 16'h0ECF};  // ADDX / ADDA overlap
      12: return {16'hB108, 16'h0EC7};  // CMPM / CMPA
      13: return {16'h50C8, 16'h0F07};  // DBcc
      14: return {16'h50C0, 16'h0F3F};  // Scc
      15: return {16'h6000, 16'h0FFF};  // Bcc, BSR
      16: return {16'hE000, 16'h0FFF};  // shifts and rotates
      17: return {16'h4000, 16'h0FFF};  // group 4
      18: return {16'h0000, 16'h0FFF};  // immediate and bit ops
      19: return {16'h80C0, 16'h0F3F};  // DIVU / DIVS
      20: return {16'hC0C0, 16'h0F3F};  // MULU / MULS
      21: return {16'h4AC0, 16'h003F};  // TAS
      22: return {16'h4EC0, 16'h013F};  // JMP, LEA
      default: return {16'h7000, 16'h0FFF};  // MOVEQ, line 7 bit 8
    endcase
  endfunction

  // {address_odd, opcode_word}
  function automatic logic [16:0] random_opcode();
    int unsigned r;
    logic [31:0] t;
    logic [15:0] w;
    r = $urandom_range(0, 99);
    w = 16'($urandom);
    if (r < 8) return {1'b1, w};
    if (r < 11) return {1'b0, 16'h0000};
    if (r < 40) return {1'b0, w};
    t = opcode_template($urandom_range(0, NUM_TEMPLATES - 1));
    return {1'b0, t[31:16] | (w & t[15:0])};
  endfunction

  task automatic send_opcode(input logic [15:0] word, input logic odd);
    res_t r;
    while (!calm && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= odd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = classify_opcode(word, odd);
    pending_decodes.push_back(r);
    words_sent++;
    if (r.halt) halts_seen++;
    if (r.unimp) unimp_seen++;
    if (!r.halt && !r.unimp) classes_seen[r.cls] = 1'b1;
  endtask

  task automatic test_directed();
    send_opcode(16'h0000, 1'b0);  // zero word halts
    send_opcode(16'h4E71, 1'b1);  // odd address halts before decode
    send_opcode(16'hFFFF, 1'b1);
    send_opcode(16'h4E72, 1'b0);  // STOP
    send_opcode(16'h4E71, 1'b0);  // NOP
    send_opcode(16'h4E75, 1'b0);  // other 4E7x word
    send_opcode(16'h4E70, 1'b0);  // RESET
    send_opcode(16'hA123, 1'b0);  // line A
    send_opcode(16'hF000, 1'b0);  // line F
    send_opcode(16'h6100, 1'b0);  // BSR
    send_opcode(16'h6F10, 1'b0);  // Bcc, cond all ones
    send_opcode(16'h003C, 1'b0);  // ORI to CCR
    send_opcode(16'h0A7C, 1'b0);  // EORI to SR
    send_opcode(16'h023C, 1'b0);  // ANDI to CCR
    send_opcode(16'h027C, 1'b0);  // ANDI to SR
    send_opcode(16'h4850, 1'b0);  // PEA
    send_opcode(16'h4E50, 1'b0);  // LINK
    send_opcode(16'h4180, 1'b0);  // CHK
    send_opcode(16'h80FF, 1'b0);  // DIVU picked by size field
    send_opcode(16'h8003, 1'b0);  // low byte 3 stays OR
    send_opcode(16'h4E00, 1'b0);  // unmatched group-4 subcode
    send_opcode(16'hD1C8, 1'b0);  // ADDA wins over ADDX
    send_opcode(16'h8108, 1'b0);  // SBCD memory form
    send_opcode(16'h57C8, 1'b0);  // DBcc
    send_opcode(16'hE8C0, 1'b0);  // memory shift with bit 11 set
  endtask

  task automatic test_random_mix();
    logic [16:0] item;
    calm = 1'b0;
    repeat (MIX_ITEMS) begin
      item = random_opcode();
      send_opcode(item[15:0], item[16]);
    end
  endtask

  // back to back with the result side always ready
  task automatic test_full_rate();
    logic [16:0] item;
    calm = 1'b1;
    repeat (FULL_RATE_ITEMS) begin
      item = random_opcode();
      send_opcode(item[15:0], item[16]);
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_decodes.size() == 0) begin
        $error("result transaction with no opcode pending: instr_class %0d", m_tdata[5:0]);
        error_count++;
      end else begin
        want = pending_decodes.pop_front();
        if (m_tdata[5:0] !== want.cls) begin
          $error("instr_class: expected %0d, got %0d", want.cls, m_tdata[5:0]);
          error_count++;
        end
        if (m_tdata[9:6] !== want.cond) begin
          $error("cond_code: expected %0d, got %0d", want.cond, m_tdata[9:6]);
          error_count++;
        end
        if (m_tdata[15:10] !== 6'd0) begin
          $error("tdata pad: expected 0, got %0d", m_tdata[15:10]);
          error_count++;
        end
        if (m_tuser[0] !== want.halt) begin
          $error("halt_flag: expected %0d, got %0d", want.halt, m_tuser[0]);
          error_count++;
        end
        if (m_tuser[1] !== want.unimp) begin
          $error("unimplemented: expected %0d, got %0d", want.unimp, m_tuser[1]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_decodes.size());
      $display("m68k_opcode_class_decoder_tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_full_rate();
    s_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("%0d opcode words decoded: %0d halted, %0d unimplemented, %0d classes hit",
             words_sent, halts_seen, unimp_seen, $countones(classes_seen));
    if (error_count == 0) begin
      $display("m68k_opcode_class_decoder_tb: done, clean");
    end else begin
      $display("m68k_opcode_class_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/m68k_pkg.sv
rtl/core/m68k_dec_core.sv
rtl/core/m68k_opcode_class_decoder.sv
tb/m68k_opcode_class_decoder_tb.sv
